/* rtl/wpf_pkg.sv */
// Shared types, sizes and codes for the waypoint path follower.
// No dependencies; every other file of the block but wpf_ram uses this package.
`timescale 1ns / 1ps
`default_nettype none

package wpf_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IW         = $clog2(MAX_POINTS);
    localparam int CW         = $clog2(MAX_POINTS + 1);
    localparam int NW         = (CW > 7) ? CW : 7;

    localparam int POS_W      = 24;
    localparam int DIFF_W     = 25;
    localparam int PROD_W     = 50;
    localparam int SS_STEPS   = 25;
    localparam int SS_CW      = $clog2(SS_STEPS);
    localparam int CFG_IW     = 3;
    localparam int CFG_DW     = 24;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IW-1:0] {
        CFG_PATH_EN   = 3'd0,
        CFG_LOOP_EN   = 3'd1,
        CFG_START_1ST = 3'd2,
        CFG_SPEED     = 3'd3,
        CFG_THRESH    = 3'd4,
        CFG_COUNT     = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        t_cmd                     command;
        logic [5:0]               point_index;
        logic signed [POS_W-1:0]  in_x;
        logic signed [POS_W-1:0]  in_y;
        logic signed [POS_W-1:0]  in_z;
        logic [15:0]              delta_time;
    } t_in_item;

    typedef struct packed {
        logic signed [POS_W-1:0]  cur_x;
        logic signed [POS_W-1:0]  cur_y;
        logic signed [POS_W-1:0]  cur_z;
        logic [5:0]               target_slot;
        logic                     target_valid;
        logic                     reached;
    } t_out_item;

    typedef enum logic {
        SS_SQRT = 1'b0,
        SS_DIV  = 1'b1
    } t_ss_mode;

    typedef struct packed {
        logic     start;
        t_ss_mode mode;
    } t_ss_req;

    typedef struct packed {
        logic              done;
        logic [DIFF_W-1:0] result;
    } t_ss_rsp;

endpackage

`default_nettype wire

/* rtl/wpf_if.sv */
// Valid/ready channel interfaces for requests into and results out of the block.
// Depends on wpf_pkg for the payload structs.
`timescale 1ns / 1ps
`default_nettype none

interface wpf_in_if;
    logic               valid;
    logic               ready;
    wpf_pkg::t_in_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface wpf_out_if;
    logic               valid;
    logic               ready;
    wpf_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/wpf_ram.sv */
// Generic single write port RAM with one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module wpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* rtl/wpf_shsub.sv */
// Shared shift-subtract unit: integer square root or division, one bit a cycle.
// Depends on wpf_pkg for widths and the request/response structs.
`timescale 1ns / 1ps
`default_nettype none

module wpf_shsub (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire wpf_pkg::t_ss_req              i_req,
    input  wire logic [wpf_pkg::PROD_W-1:0]    i_src,
    input  wire logic [wpf_pkg::DIFF_W-1:0]    i_div,
    output wpf_pkg::t_ss_rsp                   o_rsp
);
    import wpf_pkg::*;

    logic              r_busy;
    logic              r_done;
    t_ss_mode          r_mode;
    logic [SS_CW-1:0]  r_cnt;
    logic [PROD_W-1:0] r_src;
    logic [28:0]       r_rem;
    logic [DIFF_W-1:0] r_res;
    logic [DIFF_W-1:0] r_div;

    logic [28:0] rem_sh;
    logic [29:0] sub_b;
    logic [29:0] sub_d;
    logic        ge;

    // For the root the trial value is 4*root+1; for division it is the divisor.
    always_comb begin
        if (r_mode == SS_SQRT) begin
            rem_sh = {r_rem[26:0], r_src[PROD_W-1 -: 2]};
            sub_b  = {3'b000, r_res, 2'b01};
        end else begin
            rem_sh = {r_rem[27:0], r_src[PROD_W-1]};
            sub_b  = {5'b00000, r_div};
        end
        sub_d = {1'b0, rem_sh} - sub_b;
        ge    = ~sub_d[29];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == SS_CW'(SS_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mode <= i_req.mode;
            r_div  <= i_div;
            r_cnt  <= '0;
            r_res  <= '0;
            if (i_req.mode == SS_SQRT) begin
                r_src <= i_src;
                r_rem <= '0;
            end else begin
                // The quotient fits in DIFF_W bits, so the upper half is below the divisor.
                r_src <= {i_src[DIFF_W-1:0], {(PROD_W-DIFF_W){1'b0}}};
                r_rem <= {4'b0000, i_src[PROD_W-1:DIFF_W]};
            end
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            r_res <= {r_res[DIFF_W-2:0], ge};
            r_rem <= ge ? sub_d[28:0] : rem_sh;
            r_src <= (r_mode == SS_SQRT) ? {r_src[PROD_W-3:0], 2'b00}
                                         : {r_src[PROD_W-2:0], 1'b0};
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;

endmodule

`default_nettype wire

/* rtl/waypoint_path_follower.sv */
// Waypoint path follower. A load request goes from acceptance through S_OUT back to idle;
// a start request that jumps onto the first waypoint reads it in S_RD first.
// A tick reads its target, forms the products and snaps in S_CMP, or else takes the root and
// then the three divisions, one per axis, in the shift-subtract unit.
// One request is in work at a time; the next is taken once the result is registered.
// Reset (synchronous, active low) clears position, target and handshake state and restores
// the register defaults; the waypoint store holds no reset value.
`timescale 1ns / 1ps
`default_nettype none

module waypoint_path_follower (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    wpf_in_if.sink                             i_item,
    wpf_out_if.source                          o_result,
    input  wire logic                          i_cfg_we,
    input  wire logic [wpf_pkg::CFG_IW-1:0]    i_cfg_idx,
    input  wire logic [wpf_pkg::CFG_DW-1:0]    i_cfg_data
);
    import wpf_pkg::*;

    // Sequencer states. Work on a request moves through a subset of them in order.
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_RD    = 10'b0000000010,
        S_MUL   = 10'b0000000100,
        S_CMP   = 10'b0000001000,
        S_SQRT  = 10'b0000010000,
        S_AMUL  = 10'b0000100000,
        S_DIVGO = 10'b0001000000,
        S_ADIV  = 10'b0010000000,
        S_APPLY = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic        r_path_en;
    logic        r_loop_en;
    logic        r_start_1st;
    logic [23:0] r_speed;
    logic [16:0] r_thresh;
    logic [6:0]  r_count;

    // Motion state.
    logic signed [POS_W-1:0] r_px, r_py, r_pz;
    logic [IW-1:0]           r_tidx;
    logic                    r_tval;
    logic                    r_reached;

    // Working registers for one request.
    t_cmd                    r_cmd;
    logic [15:0]             r_dt;
    logic signed [POS_W-1:0] r_wx, r_wy, r_wz;
    logic [DIFF_W-1:0]       r_ax, r_ay, r_az;
    logic                    r_sx, r_sy, r_sz;
    logic [2:0]              r_cnt;
    logic [1:0]              r_axis;
    logic [PROD_W-1:0]       r_prod;
    logic [PROD_W-1:0]       r_sum;
    logic [PROD_W-1:0]       r_thr2;
    logic [PROD_W-1:0]       r_stp2;
    logic [23:0]             r_step;
    logic [DIFF_W-1:0]       r_dist;

    // Output register.
    logic      r_ov;
    t_out_item r_out;

    logic accept;
    assign accept       = i_item.valid && i_item.ready;
    assign i_item.ready = (r_state == S_IDLE);

    // Number of waypoints in use: point_count clipped to the store depth.
    logic [NW-1:0] used_n;
    always_comb begin
        if (NW'(r_count) < NW'(MAX_POINTS)) begin
            used_n = NW'(r_count);
        end else begin
            used_n = NW'(MAX_POINTS);
        end
    end

    // Target after a waypoint: the next slot, a wrap to slot zero, or none.
    logic [IW-1:0] adv_from;
    logic [IW-1:0] adv_idx;
    logic          adv_val;
    always_comb begin
        adv_from = (r_state == S_RD) ? '0 : r_tidx;
        adv_idx  = '0;
        adv_val  = 1'b0;
        if (used_n <= NW'(1)) begin
            adv_val = 1'b0;
        end else if (NW'(adv_from) + NW'(1) < used_n) begin
            adv_idx = adv_from + 1'b1;
            adv_val = 1'b1;
        end else if (r_loop_en) begin
            adv_val = 1'b1;
        end
    end

    // Waypoint store: x, y and z packed into one word per slot.
    logic                  ram_we;
    logic [IW-1:0]         ram_raddr;
    logic [3*POS_W-1:0]    ram_rdata;
    logic signed [POS_W-1:0] rd_x, rd_y, rd_z;

    assign ram_we    = accept && (i_item.data.command == CMD_LOAD)
                       && (32'(i_item.data.point_index) < MAX_POINTS);
    assign ram_raddr = (i_item.data.command == CMD_START) ? '0 : r_tidx;
    assign rd_x      = ram_rdata[3*POS_W-1 -: POS_W];
    assign rd_y      = ram_rdata[2*POS_W-1 -: POS_W];
    assign rd_z      = ram_rdata[POS_W-1:0];

    wpf_ram #(
        .WIDTH (3 * POS_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (IW'(i_item.data.point_index)),
        .i_wdata ({i_item.data.in_x, i_item.data.in_y, i_item.data.in_z}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Differences to the target, split into magnitude and sign.
    logic signed [DIFF_W-1:0] dx, dy, dz;
    assign dx = DIFF_W'(rd_x) - DIFF_W'(r_px);
    assign dy = DIFF_W'(rd_y) - DIFF_W'(r_py);
    assign dz = DIFF_W'(rd_z) - DIFF_W'(r_pz);

    // The one multiplier. Squares, the step, the threshold square, the step square and the
    // per-axis numerators are issued in turn; the product is registered every cycle.
    logic [DIFF_W-1:0] mul_a, mul_b;
    logic [DIFF_W-1:0] axis_abs;
    logic              axis_neg;
    logic signed [POS_W-1:0] axis_pos;

    always_comb begin
        case (r_axis)
            2'd0: begin
                axis_abs = r_ax;
                axis_neg = r_sx;
                axis_pos = r_px;
            end
            2'd1: begin
                axis_abs = r_ay;
                axis_neg = r_sy;
                axis_pos = r_py;
            end
            default: begin
                axis_abs = r_az;
                axis_neg = r_sz;
                axis_pos = r_pz;
            end
        endcase
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_MUL) begin
            case (r_cnt)
                3'd0: begin
                    mul_a = r_ax;
                    mul_b = r_ax;
                end
                3'd1: begin
                    mul_a = r_ay;
                    mul_b = r_ay;
                end
                3'd2: begin
                    mul_a = r_az;
                    mul_b = r_az;
                end
                3'd3: begin
                    mul_a = DIFF_W'(r_speed);
                    mul_b = DIFF_W'(r_dt);
                end
                3'd4: begin
                    mul_a = DIFF_W'(r_thresh);
                    mul_b = DIFF_W'(r_thresh);
                end
                3'd5: begin
                    mul_a = DIFF_W'(r_step);
                    mul_b = DIFF_W'(r_step);
                end
                default: begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end else if (r_state == S_AMUL) begin
            mul_a = axis_abs;
            mul_b = DIFF_W'(r_step);
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Root and division share the shift-subtract unit.
    t_ss_req ss_req;
    t_ss_rsp ss_rsp;

    assign ss_req.start = (r_state == S_CMP) || (r_state == S_DIVGO);
    assign ss_req.mode  = (r_state == S_CMP) ? SS_SQRT : SS_DIV;

    wpf_shsub u_shsub (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ss_req),
        .i_src   ((r_state == S_CMP) ? r_sum : r_prod),
        .i_div   (r_dist),
        .o_rsp   (ss_rsp)
    );

    // Snap test: inside the threshold or inside one step of the target.
    logic snap;
    assign snap = (r_sum <= r_thr2) || (r_sum <= r_stp2);

    // Signed move on the current axis, then clamp to the position range.
    logic signed [POS_W+1:0] delta;
    logic signed [POS_W+1:0] moved;
    logic signed [POS_W-1:0] moved_sat;
    always_comb begin
        delta = axis_neg ? -$signed({1'b0, ss_rsp.result}) : $signed({1'b0, ss_rsp.result});
        moved = (POS_W+2)'(axis_pos) + delta;
        if (moved > (POS_W+2)'(8388607)) begin
            moved_sat = 24'sh7FFFFF;
        end else if (moved < -(POS_W+2)'(8388608)) begin
            moved_sat = 24'sh800000;
        end else begin
            moved_sat = POS_W'(moved);
        end
    end

    // Configuration writes; an index beyond the register list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path_en   <= 1'b1;
            r_loop_en   <= 1'b1;
            r_start_1st <= 1'b1;
            r_speed     <= 24'd56320;
            r_thresh    <= 17'd4608;
            r_count     <= 7'd0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PATH_EN:   r_path_en   <= i_cfg_data[0];
                CFG_LOOP_EN:   r_loop_en   <= i_cfg_data[0];
                CFG_START_1ST: r_start_1st <= i_cfg_data[0];
                CFG_SPEED:     r_speed     <= i_cfg_data;
                CFG_THRESH:    r_thresh    <= i_cfg_data[16:0];
                CFG_COUNT:     r_count     <= i_cfg_data[6:0];
                default:       r_count     <= r_count;
            endcase
        end
    end

    // Sequencer and motion state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_px      <= '0;
            r_py      <= '0;
            r_pz      <= '0;
            r_tidx    <= '0;
            r_tval    <= 1'b0;
            r_reached <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            // In S_OUT the output register is refilled below, so it is not cleared here.
            if (o_result.valid && o_result.ready && r_state != S_OUT) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd     <= i_item.data.command;
                        r_dt      <= i_item.data.delta_time;
                        r_reached <= 1'b0;
                        r_state   <= S_OUT;
                        case (i_item.data.command)
                            CMD_START: begin
                                r_px   <= i_item.data.in_x;
                                r_py   <= i_item.data.in_y;
                                r_pz   <= i_item.data.in_z;
                                r_tidx <= '0;
                                r_tval <= 1'b0;
                                if (r_path_en && used_n != '0) begin
                                    if (r_start_1st) begin
                                        r_state <= S_RD;
                                    end else begin
                                        r_tval <= 1'b1;
                                    end
                                end
                            end
                            CMD_TICK: begin
                                if (r_path_en && used_n != '0 && r_tval && r_speed != '0) begin
                                    r_state <= S_RD;
                                end
                            end
                            default: begin
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_wx <= rd_x;
                    r_wy <= rd_y;
                    r_wz <= rd_z;
                    if (r_cmd == CMD_START) begin
                        // Jump onto the first waypoint and aim past it.
                        r_px    <= rd_x;
                        r_py    <= rd_y;
                        r_pz    <= rd_z;
                        r_tidx  <= adv_idx;
                        r_tval  <= adv_val;
                        r_state <= S_OUT;
                    end else begin
                        r_ax    <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
                        r_ay    <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
                        r_az    <= dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);
                        r_sx    <= dx[DIFF_W-1];
                        r_sy    <= dy[DIFF_W-1];
                        r_sz    <= dz[DIFF_W-1];
                        r_cnt   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    // Each product is collected in the cycle after it was issued.
                    r_cnt <= r_cnt + 1'b1;
                    case (r_cnt)
                        3'd1: r_sum  <= r_prod;
                        3'd2: r_sum  <= r_sum + r_prod;
                        3'd3: r_sum  <= r_sum + r_prod;
                        3'd4: r_step <= r_prod[39:16];
                        3'd5: r_thr2 <= r_prod;
                        3'd6: begin
                            r_stp2  <= r_prod;
                            r_state <= S_CMP;
                        end
                        default: r_sum <= r_sum;
                    endcase
                end
                S_CMP: begin
                    if (snap) begin
                        r_px      <= r_wx;
                        r_py      <= r_wy;
                        r_pz      <= r_wz;
                        r_tidx    <= adv_idx;
                        r_tval    <= adv_val;
                        r_reached <= 1'b1;
                        r_state   <= S_OUT;
                    end else begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (ss_rsp.done) begin
                        r_dist  <= ss_rsp.result;
                        r_axis  <= 2'd0;
                        r_state <= S_AMUL;
                    end
                end
                S_AMUL: begin
                    r_state <= S_DIVGO;
                end
                S_DIVGO: begin
                    r_state <= S_ADIV;
                end
                S_ADIV: begin
                    if (ss_rsp.done) begin
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    case (r_axis)
                        2'd0:    r_px <= moved_sat;
                        2'd1:    r_py <= moved_sat;
                        default: r_pz <= moved_sat;
                    endcase
                    if (r_axis == 2'd2) begin
                        r_state <= S_OUT;
                    end else begin
                        r_axis  <= r_axis + 1'b1;
                        r_state <= S_AMUL;
                    end
                end
                S_OUT: begin
                    // Hand the result over once the output register is free.
                    if (!r_ov || o_result.ready) begin
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_ov || o_result.ready)) begin
            r_out.cur_x        <= r_px;
            r_out.cur_y        <= r_py;
            r_out.cur_z        <= r_pz;
            r_out.target_slot  <= r_tval ? 6'(r_tidx) : 6'd0;
            r_out.target_valid <= r_tval;
            r_out.reached      <= r_reached;
        end
    end

    assign o_result.valid = r_ov;
    assign o_result.data  = r_out;

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for the waypoint path follower: drives load, start and tick
// requests, predicts every result in a behavioral model and checks each one in order.
// Depends on rtl/wpf_pkg.sv, rtl/wpf_if.sv and rtl/waypoint_path_follower.sv.
`timescale 1ns / 1ps

module tb_top;
    import wpf_pkg::*;

    localparam int TAIL_CYCLES = 300;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IW-1:0] i_cfg_idx;
    logic [CFG_DW-1:0] i_cfg_data;

    wpf_in_if  req_ch ();
    wpf_out_if res_ch ();

    waypoint_path_follower dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (req_ch.sink),
        .o_result   (res_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Clock with a 2 ns period.
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Shadow copy of the block state, kept by the predictor.
    logic signed [POS_W-1:0] wp_x [MAX_POINTS];
    logic signed [POS_W-1:0] wp_y [MAX_POINTS];
    logic signed [POS_W-1:0] wp_z [MAX_POINTS];
    logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
    logic [5:0]              aim_slot;
    bit                      aim_live;

    bit          path_on, loop_on, start_first;
    logic [23:0] speed;
    logic [16:0] thresh;
    logic [6:0]  npoints;

    t_out_item expected_positions [$];
    int        error_count;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        hold_cycles;

    function automatic int used_points();
        return (npoints < MAX_POINTS) ? int'(npoints) : MAX_POINTS;
    endfunction

    function automatic longint isqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic logic signed [POS_W-1:0] clamp24(longint v);
        if (v > 64'sd8388607) return 24'sh7FFFFF;
        if (v < -64'sd8388608) return 24'sh800000;
        return v[23:0];
    endfunction

    // Choose the target after slot idx, or drop the target.
    function automatic void next_target(int idx);
        int n;
        n = used_points();
        if (n <= 1) begin
            aim_live = 0; aim_slot = 0;
        end else if (idx + 1 < n) begin
            aim_live = 1; aim_slot = 6'(idx + 1);
        end else if (loop_on) begin
            aim_live = 1; aim_slot = 0;
        end else begin
            aim_live = 0; aim_slot = 0;
        end
    endfunction

    // Apply one request to the shadow state and return the position report it causes.
    function automatic t_out_item predict_position(t_in_item it);
        t_out_item r;
        longint dx, dy, dz, stp, span;
        longint unsigned sum, thr2;
        int idx;
        r = '0;
        case (it.command)
            CMD_LOAD: begin
                wp_x[it.point_index] = it.in_x;
                wp_y[it.point_index] = it.in_y;
                wp_z[it.point_index] = it.in_z;
            end
            CMD_START: begin
                pos_x = it.in_x; pos_y = it.in_y; pos_z = it.in_z;
                aim_live = 0; aim_slot = 0;
                if (path_on && used_points() != 0) begin
                    if (start_first) begin
                        pos_x = wp_x[0]; pos_y = wp_y[0]; pos_z = wp_z[0];
                        next_target(0);
                    end else begin
                        aim_live = 1;
                    end
                end
            end
            CMD_TICK: begin
                if (path_on && used_points() != 0 && aim_live && speed != 0) begin
                    idx = aim_slot;
                    dx = longint'(wp_x[idx]) - longint'(pos_x);
                    dy = longint'(wp_y[idx]) - longint'(pos_y);
                    dz = longint'(wp_z[idx]) - longint'(pos_z);
                    sum = dx * dx + dy * dy + dz * dz;
                    stp = (longint'(speed) * longint'(it.delta_time)) >>> 16;
                    thr2 = longint'(thresh) * longint'(thresh);
                    if (sum <= thr2 || sum <= stp * stp) begin
                        pos_x = wp_x[idx]; pos_y = wp_y[idx]; pos_z = wp_z[idx];
                        next_target(idx);
                        r.reached = 1'b1;
                    end else begin
                        span = isqrt(sum);
                        pos_x = clamp24(longint'(pos_x) + dx * stp / span);
                        pos_y = clamp24(longint'(pos_y) + dy * stp / span);
                        pos_z = clamp24(longint'(pos_z) + dz * stp / span);
                    end
                end
            end
            default: ;
        endcase
        r.cur_x = pos_x; r.cur_y = pos_y; r.cur_z = pos_z;
        r.target_slot = aim_live ? aim_slot : 6'd0;
        r.target_valid = aim_live;
        return r;
    endfunction

    // Send one request; it is predicted at the edge where it is accepted.
    task automatic send_request(t_in_item it);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
        end
        req_ch.valid = 1'b1;
        req_ch.data  = it;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        expected_positions.push_back(predict_position(it));
        @(negedge i_clk);
        req_ch.valid = 1'b0;
    endtask

    // Ready side: random idling, and a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            res_ch.ready <= 1'b0;
            hold_cycles  <= hold_cycles - 1;
        end else begin
            res_ch.ready <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
        end
    end

    // Every accepted result is compared with the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_positions.size() == 0) begin
                $display("%0t unexpected result: expected none, actual %h", $realtime,
                         res_ch.data);
                error_count++;
            end else begin
                want = expected_positions.pop_front();
                if (res_ch.data !== want) begin
                    $display("%0t mismatch: expected x=%h y=%h z=%h slot=%0d v=%b r=%b",
                             $realtime, want.cur_x, want.cur_y, want.cur_z,
                             want.target_slot, want.target_valid, want.reached);
                    $display("%0t          actual   x=%h y=%h z=%h slot=%0d v=%b r=%b",
                             $realtime, res_ch.data.cur_x, res_ch.data.cur_y,
                             res_ch.data.cur_z, res_ch.data.target_slot,
                             res_ch.data.target_valid, res_ch.data.reached);
                    error_count++;
                end
            end
        end
    end

    task automatic wait_drained();
        while (expected_positions.size() != 0) @(negedge i_clk);
    endtask

    // Registers change only while the block is idle.
    task automatic write_reg(t_cfg_idx idx, logic [23:0] val);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_PATH_EN:   path_on = val[0];
            CFG_LOOP_EN:   loop_on = val[0];
            CFG_START_1ST: start_first = val[0];
            CFG_SPEED:     speed = val;
            CFG_THRESH:    thresh = val[16:0];
            CFG_COUNT:     npoints = val[6:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($urandom);
            default: return 24'($signed(16'($urandom)));
        endcase
    endfunction

    function automatic t_in_item make_item(t_cmd c, int slot, logic [23:0] x, logic [23:0] y,
                                           logic [23:0] z, int dt);
        t_in_item it;
        it.command = c;
        it.point_index = 6'(slot);
        it.in_x = x; it.in_y = y; it.in_z = z;
        it.delta_time = 16'(dt);
        return it;
    endfunction

    // Loads every slot so that no tick or start ever reads an unwritten waypoint.
    task automatic load_all_slots(bit spread);
        for (int s = 0; s < MAX_POINTS; s++) begin
            if (spread)
                send_request(make_item(CMD_LOAD, s, rand_coord(), rand_coord(), rand_coord(),
                                       $urandom));
            else
                send_request(make_item(CMD_LOAD, s, 24'($signed(14'($urandom))),
                                       24'($signed(14'($urandom))),
                                       24'($signed(14'($urandom))), $urandom));
        end
    endtask

    // Extremes of the fields, every command and the named corner cases.
    task automatic test_directed();
        send_request(make_item(CMD_TICK, 0, 0, 0, 0, 16'hFFFF));      // tick with no target
        send_request(make_item(CMD_START, 0, 24'h7FFFFF, 24'h800000, 0, 0)); // no points in use
        send_request(make_item(CMD_NONE, 63, 24'hFFFFFF, 0, 24'h7FFFFF, 16'hFFFF));
        load_all_slots(1'b0);
        send_request(make_item(CMD_LOAD, 0, 24'h800000, 24'h800000, 24'h800000, 0));
        send_request(make_item(CMD_LOAD, 1, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 0));
        write_reg(CFG_COUNT, 24'd2);
        send_request(make_item(CMD_START, 0, 0, 0, 0, 0));            // jump to first point
        send_request(make_item(CMD_TICK, 0, 0, 0, 0, 0));             // zero tick length
        send_request(make_item(CMD_TICK, 0, 0, 0, 0, 16'hFFFF));
        write_reg(CFG_SPEED, 24'hFFFFFF);
        send_request(make_item(CMD_TICK, 0, 0, 0, 0, 16'hFFFF));      // full step, still short
        write_reg(CFG_COUNT, 24'd1);                                  // single point
        send_request(make_item(CMD_START, 0, 5, 5, 5, 0));
        write_reg(CFG_START_1ST, 24'd0);
        send_request(make_item(CMD_START, 0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 0));
        send_request(make_item(CMD_TICK, 0, 0, 0, 0, 16'hFFFF));
        write_reg(CFG_COUNT, 24'd127);                                // count beyond store
        write_reg(CFG_LOOP_EN, 24'd0);
        send_request(make_item(CMD_START, 0, 0, 0, 0, 0));
        write_reg(CFG_COUNT, 24'd1);                                  // stale target
        send_request(make_item(CMD_TICK, 0, 0, 0, 0, 16'hFFFF));
        write_reg(CFG_SPEED, 24'd0);
        send_request(make_item(CMD_TICK, 0, 0, 0, 0, 16'hFFFF));
        write_reg(CFG_PATH_EN, 24'd0);
        send_request(make_item(CMD_START, 0, 1, 2, 3, 0));
        write_reg(CFG_PATH_EN, 24'd1);
    endtask

    // One setting of the registers followed by a run of mostly ticks.
    task automatic run_phase(int n_items, bit spread);
        int cmd_pick;
        write_reg(CFG_PATH_EN, 24'($urandom_range(9) != 0));
        write_reg(CFG_LOOP_EN, 24'($urandom_range(1)));
        write_reg(CFG_START_1ST, 24'($urandom_range(1)));
        case ($urandom_range(3))
            0: write_reg(CFG_SPEED, 24'hFFFFFF);
            1: write_reg(CFG_SPEED, 24'($urandom_range(255)));
            default: write_reg(CFG_SPEED, 24'($urandom_range(24'hFFFFFF)));
        endcase
        case ($urandom_range(3))
            0: write_reg(CFG_THRESH, 24'd256);
            1: write_reg(CFG_THRESH, 24'd128000);
            default: write_reg(CFG_THRESH, 24'($urandom_range(128000, 256)));
        endcase
        case ($urandom_range(3))
            0: write_reg(CFG_COUNT, 24'd64);
            1: write_reg(CFG_COUNT, 24'($urandom_range(127, 65)));
            default: write_reg(CFG_COUNT, 24'($urandom_range(8)));
        endcase
        load_all_slots(spread);
        for (int k = 0; k < n_items; k++) begin
            cmd_pick = $urandom_range(99);
            if (cmd_pick < 8)
                send_request(make_item(CMD_LOAD, $urandom_range(63), rand_coord(),
                                       rand_coord(), rand_coord(), $urandom));
            else if (cmd_pick < 15)
                send_request(make_item(CMD_START, 0, rand_coord(), rand_coord(),
                                       rand_coord(), $urandom));
            else if (cmd_pick < 17)
                send_request(make_item(CMD_NONE, $urandom_range(63), rand_coord(),
                                       rand_coord(), rand_coord(), $urandom));
            else
                send_request(make_item(CMD_TICK, $urandom_range(63), rand_coord(),
                                       rand_coord(), rand_coord(), $urandom));
        end
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < 4; p++) run_phase(60, p[0]);
    endtask

    // The receiver stops for a long stretch while requests keep coming.
    task automatic test_backpressure();
        wait_drained();
        hold_cycles = 600;
        run_phase(30, 1'b0);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        res_ch.ready = 1'b0;
        error_count = 0;
        hold_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        path_on = 1; loop_on = 1; start_first = 1;
        speed = 24'd56320; thresh = 17'd4608; npoints = 7'd0;
        pos_x = 0; pos_y = 0; pos_z = 0;
        aim_slot = 0; aim_live = 0;
        for (int s = 0; s < MAX_POINTS; s++) begin
            wp_x[s] = 0; wp_y[s] = 0; wp_z[s] = 0;
        end
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 30; recv_idle_pct = 79;
        test_directed();
        test_random_traffic();
        send_idle_pct = 79; recv_idle_pct = 30;
        test_random_traffic();
        send_idle_pct = 0; recv_idle_pct = 0;
        test_backpressure();
        test_random_traffic();

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
